FILE: rtl/i32a_pkg.sv
// Shared types and codes for the mixed-width integer ALU.
`default_nettype none

package i32a_pkg;

    // Operation codes
    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_DIV  = 4'd3;
    localparam logic [3:0] ACT_EQ   = 4'd4;
    localparam logic [3:0] ACT_NE   = 4'd5;
    localparam logic [3:0] ACT_GT   = 4'd6;
    localparam logic [3:0] ACT_GE   = 4'd7;
    localparam logic [3:0] ACT_LT   = 4'd8;
    localparam logic [3:0] ACT_LE   = 4'd9;
    localparam logic [3:0] ACT_NEG  = 4'd10;
    localparam logic [3:0] ACT_HASH = 4'd11;

    // Right operand kinds
    localparam logic [2:0] RK_I8  = 3'd0;
    localparam logic [2:0] RK_I16 = 3'd1;
    localparam logic [2:0] RK_I32 = 3'd2;
    localparam logic [2:0] RK_I64 = 3'd3;

    // Result kinds
    localparam logic [1:0] KIND_I32  = 2'd0;
    localparam logic [1:0] KIND_I64  = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;
    localparam logic [1:0] KIND_SIZE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_BADTYPE = 2'd2;

    // Divider depth: quotient magnitude never exceeds 32 bits
    localparam int DIV_STEPS = 32;

    // One request in flight between stages
    typedef struct packed {
        logic        valid;
        logic        is_mul;
        logic        is_div;
        logic        narrow;
        logic        neg;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [63:0] value;
        logic [31:0] mul_hi;
        logic [63:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [63:0] den;
    } pipe_t;

endpackage

`default_nettype wire

FILE: rtl/i32a_decode.sv
// Front stages: operand extension, then compare, add, partial products and divide setup.
`default_nettype none

module i32a_decode
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  take,
    input  wire  [3:0]           action,
    input  wire  signed [31:0]   left_operand,
    input  wire  signed [63:0]   right_operand,
    input  wire  [2:0]           right_kind,
    output i32a_pkg::pipe_t      req_out
);

    logic        v1_reg;
    logic [3:0]  act1_reg;
    logic [31:0] a1_reg;
    logic [63:0] b1_reg;
    logic        bad1_reg;
    logic        wide1_reg;
    logic [63:0] b_next;
    logic        s2_valid_reg;

    i32a_pkg::pipe_t s2_next;
    i32a_pkg::pipe_t s2_reg;

    // Extend the right operand from the width its kind names
    always_comb
    begin
        unique case (right_kind)
            i32a_pkg::RK_I8:  b_next = {{56{right_operand[7]}}, right_operand[7:0]};
            i32a_pkg::RK_I16: b_next = {{48{right_operand[15]}}, right_operand[15:0]};
            i32a_pkg::RK_I32: b_next = {{32{right_operand[31]}}, right_operand[31:0]};
            default:          b_next = right_operand;
        endcase
    end

    // Hold the first stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= take;
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        act1_reg  <= action;
        a1_reg    <= left_operand;
        b1_reg    <= b_next;
        bad1_reg  <= (right_kind > i32a_pkg::RK_I64);
        wide1_reg <= (right_kind == i32a_pkg::RK_I64);
    end

    // Second stage: everything but the divide loop and the product fold
    always_comb
    begin
        logic [63:0] ae;
        logic [63:0] p0;
        logic        lt_ab;
        logic        lt_ba;
        logic [1:0]  akind;
        ae    = {{32{a1_reg[31]}}, a1_reg};
        // Unsigned low product; the sign of the left operand is folded into the high part
        p0    = {32'd0, a1_reg} * {32'd0, b1_reg[31:0]};
        lt_ab = $signed(ae) < $signed(b1_reg);
        lt_ba = $signed(b1_reg) < $signed(ae);
        akind = wide1_reg ? i32a_pkg::KIND_I64 : i32a_pkg::KIND_I32;

        s2_next        = '0;
        s2_next.valid  = v1_reg;
        s2_next.mul_hi = (a1_reg * b1_reg[63:32]) - (a1_reg[31] ? b1_reg[31:0] : 32'd0);
        s2_next.num    = a1_reg[31] ? (32'd0 - a1_reg) : a1_reg;
        s2_next.den    = b1_reg[63] ? (64'd0 - b1_reg) : b1_reg;
        s2_next.neg    = a1_reg[31] ^ b1_reg[63];

        priority if (act1_reg == i32a_pkg::ACT_NEG)
        begin
            s2_next.value  = 64'd0 - ae;
            s2_next.narrow = 1'b1;
        end
        else if (act1_reg == i32a_pkg::ACT_HASH)
        begin
            s2_next.value = ae;
            s2_next.kind  = i32a_pkg::KIND_SIZE;
        end
        else if (act1_reg > i32a_pkg::ACT_HASH)
            s2_next.status = i32a_pkg::ST_BADTYPE;
        else if (bad1_reg)
        begin
            // Foreign type: only equality tests have an answer
            if (act1_reg == i32a_pkg::ACT_EQ)
                s2_next.kind = i32a_pkg::KIND_BOOL;
            else if (act1_reg == i32a_pkg::ACT_NE)
            begin
                s2_next.kind  = i32a_pkg::KIND_BOOL;
                s2_next.value = 64'd1;
            end
            else
                s2_next.status = i32a_pkg::ST_BADTYPE;
        end
        else
        begin
            unique case (act1_reg)
                i32a_pkg::ACT_ADD:
                begin
                    s2_next.value  = ae + b1_reg;
                    s2_next.kind   = akind;
                    s2_next.narrow = !wide1_reg;
                end
                i32a_pkg::ACT_SUB:
                begin
                    s2_next.value  = ae - b1_reg;
                    s2_next.kind   = akind;
                    s2_next.narrow = !wide1_reg;
                end
                i32a_pkg::ACT_MUL:
                begin
                    s2_next.value  = p0;
                    s2_next.is_mul = 1'b1;
                    s2_next.kind   = akind;
                    s2_next.narrow = !wide1_reg;
                end
                i32a_pkg::ACT_DIV:
                begin
                    if (b1_reg == 64'd0)
                        s2_next.status = i32a_pkg::ST_DIV0;
                    else
                    begin
                        s2_next.is_div = 1'b1;
                        s2_next.kind   = akind;
                        s2_next.narrow = !wide1_reg;
                    end
                end
                i32a_pkg::ACT_EQ:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, ae == b1_reg};
                end
                i32a_pkg::ACT_NE:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, ae != b1_reg};
                end
                i32a_pkg::ACT_GT:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, lt_ba};
                end
                i32a_pkg::ACT_GE:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, !lt_ab};
                end
                i32a_pkg::ACT_LT:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, lt_ab};
                end
                default:
                begin
                    s2_next.kind  = i32a_pkg::KIND_BOOL;
                    s2_next.value = {63'd0, !lt_ba};
                end
            endcase
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_next.valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    // Present the payload with the reset-clean valid bit
    always_comb
    begin
        req_out       = s2_reg;
        req_out.valid = s2_valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/i32a_div_stage.sv
// One restoring-division step: produce one quotient bit per stage.
`default_nettype none

module i32a_div_stage
(
    input  wire              clk,
    input  wire              rst_n,
    input  i32a_pkg::pipe_t  req_in,
    output i32a_pkg::pipe_t  req_out
);

    logic            st_valid_reg;
    i32a_pkg::pipe_t st_next;
    i32a_pkg::pipe_t st_reg;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb
    begin
        logic [64:0] trial;
        logic [64:0] diff;
        logic        fits;
        trial = {req_in.rem, req_in.num[31]};
        diff  = trial - {1'b0, req_in.den};
        fits  = (trial >= {1'b0, req_in.den});

        st_next     = req_in;
        st_next.rem = fits ? diff[63:0] : trial[63:0];
        st_next.num = {req_in.num[30:0], 1'b0};
        st_next.quo = {req_in.quo[30:0], fits};
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_next.valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    // Present the payload with the reset-clean valid bit
    always_comb
    begin
        req_out       = st_reg;
        req_out.valid = st_valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/int32_mixed_width_alu.sv
// Top level of the mixed-width integer ALU: front stages, divide chain, output register.
// Usage: busy is always low, so a request can be started on every clock cycle. Every
// request gives exactly one result, shown for one cycle with done high, after passing
// two front stages, a product fold stage, one stage per quotient bit of the 32-step
// restoring divider, and the output register. All operations pass through the same
// registers, so results leave in request order.
// The receiver cannot hold a result off: it must take it in the cycle done is high.
`default_nettype none

module int32_mixed_width_alu
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [3:0]          action,
    input  wire  signed [31:0]  left_operand,
    input  wire  signed [63:0]  right_operand,
    input  wire  [2:0]          right_kind,
    output logic                done,
    output logic signed [63:0]  result_value,
    output logic [1:0]          result_kind,
    output logic [1:0]          status
);

    i32a_pkg::pipe_t s2;
    i32a_pkg::pipe_t s3_next;
    i32a_pkg::pipe_t s3_reg;
    i32a_pkg::pipe_t s3_out;
    i32a_pkg::pipe_t chain [i32a_pkg::DIV_STEPS+1];

    logic        s3_valid_reg;
    logic        done_reg;
    logic [63:0] value_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  status_reg;
    logic [63:0] value_next;

    assign busy = 1'b0;

    i32a_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (start),
        .action        (action),
        .left_operand  (left_operand),
        .right_operand (right_operand),
        .right_kind    (right_kind),
        .req_out       (s2)
    );

    // Fold the high partial product, narrow 32-bit arithmetic
    always_comb
    begin
        logic [63:0] v;
        v = s2.is_mul ? (s2.value + {s2.mul_hi, 32'd0}) : s2.value;
        s3_next = s2;
        if (s2.narrow && !s2.is_div)
            s3_next.value = {{32{v[31]}}, v[31:0]};
        else
            s3_next.value = v;
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s3_next.valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
    end

    // Present the payload with the reset-clean valid bit
    always_comb
    begin
        s3_out       = s3_reg;
        s3_out.valid = s3_valid_reg;
    end

    assign chain[0] = s3_out;

    // Divide chain, one quotient bit per stage
    for (genvar i = 0; i < i32a_pkg::DIV_STEPS; i++)
    begin : g_div
        i32a_div_stage u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .req_in  (chain[i]),
            .req_out (chain[i+1])
        );
    end

    // Apply the quotient sign and width
    always_comb
    begin
        logic [63:0] q;
        q = chain[i32a_pkg::DIV_STEPS].neg ? (64'd0 - {32'd0, chain[i32a_pkg::DIV_STEPS].quo})
                                           : {32'd0, chain[i32a_pkg::DIV_STEPS].quo};
        if (!chain[i32a_pkg::DIV_STEPS].is_div)
            value_next = chain[i32a_pkg::DIV_STEPS].value;
        else if (chain[i32a_pkg::DIV_STEPS].narrow)
            value_next = {{32{q[31]}}, q[31:0]};
        else
            value_next = q;
    end

    // Hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[i32a_pkg::DIV_STEPS].valid;
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        kind_reg   <= chain[i32a_pkg::DIV_STEPS].kind;
        status_reg <= chain[i32a_pkg::DIV_STEPS].status;
    end

    assign done         = done_reg;
    assign result_value = value_reg;
    assign result_kind  = kind_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

FILE: rtl/i32a_checker.sv
// Port-level checks for the mixed-width integer ALU and their binding.
`default_nettype none

module i32a_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         busy,
    input  wire         done,
    input  wire  [63:0] result_value,
    input  wire  [1:0]  result_kind,
    input  wire  [1:0]  status
);

    // The pipeline never refuses a request
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Errors carry zero value and kind
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != i32a_pkg::ST_OK)
            |-> (result_value == 64'd0 && result_kind == i32a_pkg::KIND_I32))
        else $error("error result not cleared");

    // Booleans are 0 or 1
    a_bool_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == i32a_pkg::KIND_BOOL) |-> (result_value[63:1] == 63'd0))
        else $error("boolean result out of range");

    // Narrow int results are sign-extended
    a_i32_sext: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == i32a_pkg::KIND_I32)
            |-> (result_value[63:32] == {32{result_value[31]}}))
        else $error("int32 result not sign-extended");

endmodule

bind int32_mixed_width_alu i32a_checker u_i32a_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .result_kind  (result_kind),
    .status       (status)
);

`default_nettype wire

FILE: dv/tb_int32_mixed_width_alu.sv
// Testbench for the mixed-width integer ALU: random and directed requests checked against a predictor.
`default_nettype none

module tb_int32_mixed_width_alu;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  kind;
        logic [1:0]  st;
    } alu_result_t;

    // Work out the result of one request
    function automatic alu_result_t compute_alu(logic [3:0] act, logic [31:0] lhs,
                                                logic [63:0] rhs, logic [2:0] rk);
        alu_result_t res;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        res.value = '0;
        res.kind = i32a_pkg::KIND_I32;
        res.st = i32a_pkg::ST_OK;
        a = {{32{lhs[31]}}, lhs};
        if (act == i32a_pkg::ACT_NEG)
        begin
            r = -a;
            res.value = {{32{r[31]}}, r[31:0]};
            return res;
        end
        if (act == i32a_pkg::ACT_HASH)
        begin
            res.value = a;
            res.kind = i32a_pkg::KIND_SIZE;
            return res;
        end
        if (act > i32a_pkg::ACT_HASH)
        begin
            res.st = i32a_pkg::ST_BADTYPE;
            return res;
        end
        if (rk > i32a_pkg::RK_I64)
        begin
            if (act == i32a_pkg::ACT_EQ || act == i32a_pkg::ACT_NE)
            begin
                res.kind = i32a_pkg::KIND_BOOL;
                res.value = (act == i32a_pkg::ACT_NE) ? 64'd1 : 64'd0;
            end
            else
            begin
                res.st = i32a_pkg::ST_BADTYPE;
            end
            return res;
        end
        case (rk)
            i32a_pkg::RK_I8:  b = {{56{rhs[7]}}, rhs[7:0]};
            i32a_pkg::RK_I16: b = {{48{rhs[15]}}, rhs[15:0]};
            i32a_pkg::RK_I32: b = {{32{rhs[31]}}, rhs[31:0]};
            default:          b = rhs;
        endcase
        r = '0;
        case (act)
            i32a_pkg::ACT_ADD: r = a + b;
            i32a_pkg::ACT_SUB: r = a - b;
            i32a_pkg::ACT_MUL: r = a * b;
            i32a_pkg::ACT_DIV:
            begin
                if (b == 0)
                begin
                    res.st = i32a_pkg::ST_DIV0;
                    return res;
                end
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                q = ma / mb;
                r = (a[63] != b[63]) ? -q : q;
            end
            default:
            begin
                res.kind = i32a_pkg::KIND_BOOL;
                case (act)
                    i32a_pkg::ACT_EQ: res.value = {63'd0, a == b};
                    i32a_pkg::ACT_NE: res.value = {63'd0, a != b};
                    i32a_pkg::ACT_GT: res.value = {63'd0, a > b};
                    i32a_pkg::ACT_GE: res.value = {63'd0, a >= b};
                    i32a_pkg::ACT_LT: res.value = {63'd0, a < b};
                    default:          res.value = {63'd0, a <= b};
                endcase
                return res;
            end
        endcase
        if (rk == i32a_pkg::RK_I64)
        begin
            res.value = r;
            res.kind = i32a_pkg::KIND_I64;
        end
        else
        begin
            res.value = {{32{r[31]}}, r[31:0]};
        end
        return res;
    endfunction

    // Hold expected results in request order and compare
    class alu_scoreboard;
        alu_result_t pending[$];
        int mismatches = 0;

        function void note_request(logic [3:0] act, logic [31:0] lhs,
                                   logic [63:0] rhs, logic [2:0] rk);
            pending.push_back(compute_alu(act, lhs, rhs, rk));
        endfunction

        function void check_result(logic [63:0] v, logic [1:0] k, logic [1:0] s);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h kind=%0d status=%0d", v, k, s);
                return;
            end
            e = pending.pop_front();
            if (v !== e.value || k !== e.kind || s !== e.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                             e.value, e.kind, e.st, v, k, s);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  action;
    logic [31:0] left_operand;
    logic [63:0] right_operand;
    logic [2:0]  right_kind;
    logic        done;
    logic [63:0] result_value;
    logic [1:0]  result_kind;
    logic [1:0]  status;

    alu_scoreboard sb;
    int idle_pct;
    int n_sent;
    int n_checked = 0;
    longint cycles = 0;

    int32_mixed_width_alu u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .left_operand(left_operand),
        .right_operand(right_operand), .right_kind(right_kind),
        .done(done), .result_value(result_value),
        .result_kind(result_kind), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check results and count cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            sb.check_result(result_value, result_kind, status);
            n_checked <= n_checked + 1;
        end
        if (cycles > 200000)
        begin
            $display("timeout");
            $display("tb_int32_mixed_width_alu: errors");
            $finish;
        end
    end

    // Issue one request, with optional idle cycles before it
    task automatic send_request(logic [3:0] act, logic [31:0] lhs,
                                logic [63:0] rhs, logic [2:0] rk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        left_operand <= lhs;
        right_operand <= rhs;
        right_kind <= rk;
        do @(posedge clk); while (busy);
        sb.note_request(act, lhs, rhs, rk);
        n_sent++;
    endtask

    function automatic logic [31:0] pick_lhs();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(3) - 1;
            3: return {{24{1'b0}}, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_rhs();
        case ($urandom_range(5))
            0: return 64'h0;
            1: return 64'hffff_ffff_ffff_ffff;
            2: return 64'h8000_0000_0000_0000;
            3: return {$urandom, $urandom} >> $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Wait until every expected result has arrived
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [3:0] act;
        logic [2:0] rk;
        sb = new();
        n_sent = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = '0;
        left_operand = '0;
        right_operand = '0;
        right_kind = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, special cases
        for (int a = 0; a < 12; a++)
            send_request(4'(a), 32'h8000_0000, 64'hffff_ffff_ffff_ff85, i32a_pkg::RK_I8);
        send_request(i32a_pkg::ACT_DIV, 32'h8000_0000, 64'hffff_ffff_ffff_ffff,
                     i32a_pkg::RK_I32);
        send_request(i32a_pkg::ACT_DIV, 32'h7fff_ffff, 64'hffff_ffff_ffff_ff00,
                     i32a_pkg::RK_I8);
        send_request(i32a_pkg::ACT_DIV, 32'd5, 64'h8000_0000_0000_0000, i32a_pkg::RK_I64);
        send_request(i32a_pkg::ACT_EQ, 32'd1, 64'd1, 3'd4);
        send_request(i32a_pkg::ACT_NE, 32'd1, 64'd1, 3'd7);
        send_request(i32a_pkg::ACT_ADD, 32'd1, 64'd1, 3'd5);
        send_request(i32a_pkg::ACT_NEG, 32'h8000_0000, 64'd0, 3'd6);
        send_request(4'd15, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, i32a_pkg::RK_I64);
        send_request(i32a_pkg::ACT_SUB, 32'h8000_0000, 64'h0001_8000, i32a_pkg::RK_I16);
        send_request(i32a_pkg::ACT_MUL, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff,
                     i32a_pkg::RK_I64);
        send_request(i32a_pkg::ACT_GE, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
                     i32a_pkg::RK_I64);
        send_request(i32a_pkg::ACT_LE, 32'd0, 64'h8000_0000_0000_0000, i32a_pkg::RK_I64);
        send_request(i32a_pkg::ACT_HASH, 32'hffff_ffff, 64'h0, 3'd4);

        // Pause until the pipeline is empty
        drain();

        // Random phases: no idling, mostly idle, lightly idle, none again
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 59 : (ph == 2) ? 12 : 0;
            for (int i = 0; i < 160; i++)
            begin
                act = ($urandom_range(19) == 0) ? 4'(12 + $urandom_range(3))
                                                : 4'($urandom_range(11));
                rk = ($urandom_range(9) == 0) ? 3'(4 + $urandom_range(3))
                                              : 3'($urandom_range(3));
                send_request(act, pick_lhs(), pick_rhs(), rk);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("sent %0d requests, checked %0d results, all 12 operations", n_sent, n_checked);
        $display("covered: width kinds, other types, divide by zero, overflow wrap, idle gaps");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_int32_mixed_width_alu: clean");
        else
            $display("tb_int32_mixed_width_alu: errors");
        $finish;
    end

endmodule

`default_nettype wire
